// File: rtl/dmah_pkg.sv
// Shared widths, constants, types and reciprocal factors for the dual moving average block.
`timescale 1ns / 1ps
package dmah_pkg;

    // Window length of both moving averages.
    localparam int WINDOW = 10;

    // Field widths.
    localparam int SAMPLE_W   = 12;
    localparam int GAIN_W     = 18;
    localparam int DB_W       = 16;
    localparam int BAT_W      = 17;
    localparam int EAR_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    // Register reset values and the battery saturation limit.
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(77634);
    localparam logic [DB_W-1:0]   DB_RESET   = DB_W'(800);
    localparam logic [BAT_W-1:0]  BAT_MAX    = BAT_W'(77616);

    // Running sum width: exact for WINDOW full-scale samples.
    localparam int SUM_W = $clog2(WINDOW * 4095 + 1);

    // Battery path: sum times gain, drop 12 fraction bits, divide by WINDOW.
    localparam int PROD_W     = SUM_W + GAIN_W;
    localparam int FRAC_SHIFT = 12;
    localparam int BQ_W       = PROD_W - FRAC_SHIFT;
    localparam int WIN_LOG    = $clog2(WINDOW);
    localparam int B_SHIFT    = BQ_W + WIN_LOG;
    localparam int B_RECIP_W  = BQ_W + 1;
    localparam int BQP_W      = BQ_W + B_RECIP_W;
    localparam longint unsigned B_RECIP_L =
        ((64'd1 << B_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [B_RECIP_W-1:0] B_RECIP = B_RECIP_W'(B_RECIP_L);

    // Earphone path: sum times 16, divide by WINDOW.
    localparam int EN_W      = SUM_W + 4;
    localparam int E_SHIFT   = EN_W + WIN_LOG;
    localparam int E_RECIP_W = EN_W + 1;
    localparam int EP_W      = EN_W + E_RECIP_W;
    localparam longint unsigned E_RECIP_L =
        ((64'd1 << E_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [E_RECIP_W-1:0] E_RECIP = E_RECIP_W'(E_RECIP_L);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN     = 1'b0,
        CFG_DEADBAND = 1'b1
    } cfg_reg_t;

    // Pipeline control handed from the top level to the scaling pipeline.
    typedef struct packed {
        logic advance;
        logic final_valid;
    } pipe_ctrl_t;

endpackage

// File: rtl/dmah_cell.sv
// One window cell: holds one battery and one earphone sample and passes them on.
`timescale 1ns / 1ps
module dmah_cell
    import dmah_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic [SAMPLE_W-1:0] bat_in,
    input  logic [SAMPLE_W-1:0] ear_in,
    output logic [SAMPLE_W-1:0] bat_out,
    output logic [SAMPLE_W-1:0] ear_out
);

    logic [SAMPLE_W-1:0] bat_reg;
    logic [SAMPLE_W-1:0] ear_reg;

    // The window starts cleared, so a cell resets to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bat_reg <= '0;
            ear_reg <= '0;
        end
        else if (shift)
        begin
            bat_reg <= bat_in;
            ear_reg <= ear_in;
        end
    end

    assign bat_out = bat_reg;
    assign ear_out = ear_reg;

endmodule

// File: rtl/dmah_chain.sv
// Row of window cells with the two running sums of their contents.
`timescale 1ns / 1ps
module dmah_chain
    import dmah_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic [SAMPLE_W-1:0] bat_sample,
    input  logic [SAMPLE_W-1:0] ear_sample,
    output logic [SUM_W-1:0]    bat_sum,
    output logic [SUM_W-1:0]    ear_sum
);

    logic [SAMPLE_W-1:0] bat_tap [0:WINDOW];
    logic [SAMPLE_W-1:0] ear_tap [0:WINDOW];
    logic [SUM_W-1:0]    bat_sum_reg;
    logic [SUM_W-1:0]    bat_sum_next;
    logic [SUM_W-1:0]    ear_sum_reg;
    logic [SUM_W-1:0]    ear_sum_next;

    assign bat_tap[0] = bat_sample;
    assign ear_tap[0] = ear_sample;

    // The cells form a shift line; the last tap is the sample leaving the window.
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        dmah_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (shift),
            .bat_in  (bat_tap[i]),
            .ear_in  (ear_tap[i]),
            .bat_out (bat_tap[i+1]),
            .ear_out (ear_tap[i+1])
        );
    end

    // Add the incoming sample and remove the outgoing one.
    always_comb
    begin
        bat_sum_next = bat_sum_reg + SUM_W'(bat_sample) - SUM_W'(bat_tap[WINDOW]);
        ear_sum_next = ear_sum_reg + SUM_W'(ear_sample) - SUM_W'(ear_tap[WINDOW]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bat_sum_reg <= '0;
            ear_sum_reg <= '0;
        end
        else if (shift)
        begin
            bat_sum_reg <= bat_sum_next;
            ear_sum_reg <= ear_sum_next;
        end
    end

    assign bat_sum = bat_sum_reg;
    assign ear_sum = ear_sum_reg;

endmodule

// File: rtl/dmah_scale.sv
// Scaling pipeline: gain multiply, divide by the window, clamp and deadband hold.
`timescale 1ns / 1ps
module dmah_scale
    import dmah_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pipe_ctrl_t        ctrl,
    input  logic [SUM_W-1:0]  bat_sum,
    input  logic [SUM_W-1:0]  ear_sum,
    input  logic [GAIN_W-1:0] gain,
    input  logic [DB_W-1:0]   deadband,
    output logic [BAT_W-1:0]  battery_mv,
    output logic              updated,
    output logic [EAR_W-1:0]  ear_avg
);

    logic [PROD_W-1:0] bprod_reg;
    logic [PROD_W-1:0] bprod_next;
    logic [EP_W-1:0]   eprod_reg;
    logic [EP_W-1:0]   eprod_next;
    logic [BQ_W-1:0]   bq;
    logic [BQP_W-1:0]  bqp_reg;
    logic [BQP_W-1:0]  bqp_next;
    logic [EAR_W-1:0]  ear_s3_reg;
    logic [GAIN_W-1:0] cand_raw;
    logic [BAT_W-1:0]  cand;
    logic [BAT_W-1:0]  diff;
    logic              take;
    logic [BAT_W-1:0]  held_reg;
    logic [BAT_W-1:0]  held_next;
    logic              updated_reg;
    logic [EAR_W-1:0]  ear_out_reg;

    // Second stage: battery sum times gain, earphone sum times 16 times 1/WINDOW.
    always_comb
    begin
        bprod_next = PROD_W'(bat_sum) * PROD_W'(gain);
        eprod_next = EP_W'({ear_sum, 4'b0000}) * EP_W'(E_RECIP);
    end

    // Third stage: drop the gain fraction and multiply by 1/WINDOW.
    always_comb
    begin
        bq       = bprod_reg[PROD_W-1:FRAC_SHIFT];
        bqp_next = BQP_W'(bq) * BQP_W'(B_RECIP);
    end

    // Output stage: saturate the candidate and apply the deadband.
    always_comb
    begin
        cand_raw = bqp_reg[B_SHIFT +: GAIN_W];
        if (cand_raw > GAIN_W'(BAT_MAX))
        begin
            cand = BAT_MAX;
        end
        else
        begin
            cand = cand_raw[BAT_W-1:0];
        end
        if (cand > held_reg)
        begin
            diff = cand - held_reg;
        end
        else
        begin
            diff = held_reg - cand;
        end
        take      = diff > BAT_W'(deadband);
        held_next = take ? cand : held_reg;
    end

    // Data stages move together whenever the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            bprod_reg   <= bprod_next;
            eprod_reg   <= eprod_next;
            bqp_reg     <= bqp_next;
            ear_s3_reg  <= eprod_reg[E_SHIFT +: EAR_W];
            updated_reg <= take;
            ear_out_reg <= ear_s3_reg;
        end
    end

    // The held voltage is state and moves only when a real request reaches the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (ctrl.advance && ctrl.final_valid)
        begin
            held_reg <= held_next;
        end
    end

    assign battery_mv = held_reg;
    assign updated    = updated_reg;
    assign ear_avg    = ear_out_reg;

`ifndef SYNTHESIS
    // The held voltage never exceeds the saturation limit.
    a_held_limit: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= BAT_MAX)
        else $error("held battery voltage above limit");

    // The update flag of a request matches a real change of the held voltage.
    a_update_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.advance && ctrl.final_valid) |=>
            (updated_reg == (held_reg != $past(held_reg))))
        else $error("update flag disagrees with held voltage");

    // The held voltage is left alone while no request enters the output stage.
    a_held_still: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.advance && ctrl.final_valid) |=> $stable(held_reg))
        else $error("held voltage changed without a request");
`endif

endmodule

// File: rtl/dual_moving_average_hysteresis.sv
// Top level of the dual moving average with deadband hysteresis.
//
// Input requests carry one battery sample and one earphone sample on a
// valid/ready channel; each request yields exactly one result request on the
// output valid/ready channel, in order.
// Throughput: one request per cycle unless the receiver stalls; the
// four-stage pipeline (window update, gain and reciprocal multiply, divide
// by the window, deadband hold) lets a new request follow in every cycle
// while older ones are still at work.
// Receiver stall: while a result waits unaccepted, the whole pipeline holds
// and in_ready falls; nothing is dropped or repeated.
// Reset (rst_n low) clears the window cells, both running sums, the held
// battery voltage and the pipeline, and loads the default gain and deadband.
// Configuration: cfg_write with cfg_index and cfg_data writes a register at
// once; index 0 is the battery gain, index 1 the deadband. Write only while
// the block is idle.
`timescale 1ns / 1ps
module dual_moving_average_hysteresis
    import dmah_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SAMPLE_W-1:0]   battery_sample,
    input  logic [SAMPLE_W-1:0]   earphone_sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BAT_W-1:0]      battery_mv_q4,
    output logic                  battery_updated,
    output logic [EAR_W-1:0]      earphone_avg_q4
);

    logic [GAIN_W-1:0] gain_reg;
    logic [DB_W-1:0]   deadband_reg;
    logic              advance;
    logic              accept;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  bat_sum;
    logic [SUM_W-1:0]  ear_sum;
    pipe_ctrl_t        ctrl;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= GAIN_RESET;
            deadband_reg <= DB_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_GAIN:     gain_reg     <= cfg_data[GAIN_W-1:0];
                CFG_DEADBAND: deadband_reg <= cfg_data[DB_W-1:0];
                default:      ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or being emptied.
    always_comb
    begin
        advance          = !out_valid_reg || out_ready;
        accept           = in_valid && advance;
        ctrl.advance     = advance;
        ctrl.final_valid = v3_reg;
    end

    // Valid bits of the pipeline stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // Window cells and running sums.
    dmah_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (accept),
        .bat_sample (battery_sample),
        .ear_sample (earphone_sample),
        .bat_sum    (bat_sum),
        .ear_sum    (ear_sum)
    );

    // Scaling, division, clamp and hysteresis.
    dmah_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .bat_sum    (bat_sum),
        .ear_sum    (ear_sum),
        .gain       (gain_reg),
        .deadband   (deadband_reg),
        .battery_mv (battery_mv_q4),
        .updated    (battery_updated),
        .ear_avg    (earphone_avg_q4)
    );

    assign in_ready  = advance;
    assign out_valid = out_valid_reg;

endmodule
